FILE: hw/rtl/rpn_pkg.sv
// Shared types and constants for the stack calculator.
package rpn_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int DATA_W      = 32;
	localparam int KIND_W      = 3;
	localparam int STATUS_W    = 3;
	localparam int DEPTH_W     = 7;
	localparam int DIV_STEPS   = 32;
	localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH = 3'd0,
		KIND_ADD  = 3'd1,
		KIND_SUB  = 3'd2,
		KIND_MUL  = 3'd3,
		KIND_DIV  = 3'd4,
		KIND_SWAP = 3'd5,
		KIND_DUP  = 3'd6
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 3'd0,
		STATUS_EMPTY   = 3'd1,
		STATUS_FEW     = 3'd2,
		STATUS_DIVZERO = 3'd3,
		STATUS_FULL    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OP,
		ST_DIV,
		ST_WR,
		ST_SWP
	} state_t;

endpackage

FILE: hw/rtl/rpn_stack_calculator.sv
// Stack calculator top level: command sequencer around the stack RAM.
// Push, duplicate, no-op and every refused command complete from the idle state; add and
// subtract finish in ST_OP, as does divide by zero; multiply goes ST_OP then ST_WR, swap
// ST_OP then ST_SWP; divide goes ST_OP, the shift-subtract divider in ST_DIV, then ST_WR.
// busy falls in the cycle the result strobe shows, so a new command may follow at once;
// one command is taken at a time. The receiver cannot stall; done is a one-cycle strobe.
// Reset (arst_n low) empties the stack at once; RAM contents are left as they are.
module rpn_stack_calculator #(
	parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [rpn_pkg::KIND_W-1:0]         kind,
	input  logic signed [rpn_pkg::DATA_W-1:0]  operand,
	output logic                               done,
	output logic [rpn_pkg::STATUS_W-1:0]       status,
	output logic signed [rpn_pkg::DATA_W-1:0]  top_value,
	output logic [rpn_pkg::DEPTH_W-1:0]        depth
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int DW = rpn_pkg::DATA_W;

	// Sequencer state and stack pointer
	rpn_pkg::state_t  state_q, state_d;
	rpn_pkg::kind_t   kind_q, kind_d;
	rpn_pkg::status_t status_q, status_d;
	logic             done_q, done_d;
	logic [CW-1:0]    count_q, count_d;
	// Cached copy of the top entry, so the second operand is the only RAM read
	logic [DW-1:0]    top_q, top_d;
	// Product, or the old top held across the two swap writes
	logic [DW-1:0]    res_q, res_d;

	// Shift-subtract divider on magnitudes
	logic [DW-1:0]                  rem_q, rem_d;
	logic [DW-1:0]                  quo_q, quo_d;
	logic [DW-1:0]                  den_q, den_d;
	logic                           neg_q, neg_d;
	logic [rpn_pkg::DIV_CNT_W-1:0]  dcnt_q, dcnt_d;
	logic [DW:0]                    div_sh;
	logic [DW:0]                    div_diff;
	logic [DW-1:0]                  quo_fix;

	// RAM port
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [DW-1:0] mem_rdata;

	logic          accept;
	logic          is_empty;
	logic          is_full;
	logic          is_one;
	logic [CW-1:0] cnt_m1;
	logic [CW-1:0] cnt_m2;
	logic [DW-1:0] op_sum;
	logic [DW-1:0] op_diff;

	rpn_ram #(
		.WIDTH (DW),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign accept   = start && !busy;
	assign is_empty = (count_q == '0);
	assign is_one   = (count_q == CW'(1));
	assign is_full  = (count_q == CW'(STACK_DEPTH));
	assign cnt_m1   = count_q - CW'(1);
	assign cnt_m2   = count_q - CW'(2);

	// Second operand arrives from the RAM; top comes from the cache
	assign op_sum  = mem_rdata + top_q;
	assign op_diff = mem_rdata - top_q;

	// One divider step: shift in the next numerator bit, subtract if it fits
	assign div_sh   = {rem_q, quo_q[DW-1]};
	assign div_diff = div_sh - {1'b0, den_q};
	assign quo_fix  = neg_q ? (DW'(0) - quo_q) : quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= rpn_pkg::ST_IDLE;
			done_q   <= 1'b0;
			status_q <= rpn_pkg::STATUS_OK;
			count_q  <= '0;
			top_q    <= '0;
		end else begin
			state_q  <= state_d;
			done_q   <= done_d;
			status_q <= status_d;
			count_q  <= count_d;
			top_q    <= top_d;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		res_q  <= res_d;
		rem_q  <= rem_d;
		quo_q  <= quo_d;
		den_q  <= den_d;
		neg_q  <= neg_d;
		dcnt_q <= dcnt_d;
	end

	always_comb begin
		state_d   = state_q;
		kind_d    = kind_q;
		status_d  = status_q;
		done_d    = 1'b0;
		count_d   = count_q;
		top_d     = top_q;
		res_d     = res_q;
		rem_d     = rem_q;
		quo_d     = quo_q;
		den_d     = den_q;
		neg_d     = neg_q;
		dcnt_d    = dcnt_q;
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = top_q;
		mem_re    = 1'b0;
		mem_raddr = cnt_m2[AW-1:0];

		case (state_q)
			rpn_pkg::ST_IDLE: begin
				if (accept) begin
					kind_d   = rpn_pkg::kind_t'(kind);
					status_d = rpn_pkg::STATUS_OK;
					done_d   = 1'b1;
					case (rpn_pkg::kind_t'(kind))
						rpn_pkg::KIND_PUSH: begin
							if (is_full) begin
								status_d = rpn_pkg::STATUS_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_wdata = operand;
								top_d     = operand;
								count_d   = count_q + CW'(1);
							end
						end
						rpn_pkg::KIND_DUP: begin
							if (is_empty) begin
								status_d = rpn_pkg::STATUS_EMPTY;
							end else if (is_full) begin
								status_d = rpn_pkg::STATUS_FULL;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB, rpn_pkg::KIND_MUL,
						rpn_pkg::KIND_DIV, rpn_pkg::KIND_SWAP: begin
							if (is_empty) begin
								status_d = rpn_pkg::STATUS_EMPTY;
							end else if (is_one) begin
								status_d = rpn_pkg::STATUS_FEW;
							end else begin
								// fetch the second entry; result follows later
								mem_re  = 1'b1;
								done_d  = 1'b0;
								state_d = rpn_pkg::ST_OP;
							end
						end
						default: begin
							// unused code: no operation
						end
					endcase
				end
			end
			rpn_pkg::ST_OP: begin
				case (kind_q)
					rpn_pkg::KIND_ADD, rpn_pkg::KIND_SUB: begin
						mem_we    = 1'b1;
						mem_waddr = cnt_m2[AW-1:0];
						mem_wdata = (kind_q == rpn_pkg::KIND_ADD) ? op_sum : op_diff;
						top_d     = mem_wdata;
						count_d   = cnt_m1;
						done_d    = 1'b1;
						state_d   = rpn_pkg::ST_IDLE;
					end
					rpn_pkg::KIND_MUL: begin
						res_d   = mem_rdata * top_q;
						state_d = rpn_pkg::ST_WR;
					end
					rpn_pkg::KIND_DIV: begin
						if (top_q == '0) begin
							status_d = rpn_pkg::STATUS_DIVZERO;
							done_d   = 1'b1;
							state_d  = rpn_pkg::ST_IDLE;
						end else begin
							rem_d   = '0;
							quo_d   = mem_rdata[DW-1] ? (DW'(0) - mem_rdata) : mem_rdata;
							den_d   = top_q[DW-1] ? (DW'(0) - top_q) : top_q;
							neg_d   = mem_rdata[DW-1] ^ top_q[DW-1];
							dcnt_d  = '0;
							state_d = rpn_pkg::ST_DIV;
						end
					end
					rpn_pkg::KIND_SWAP: begin
						mem_we    = 1'b1;
						mem_waddr = cnt_m1[AW-1:0];
						mem_wdata = mem_rdata;
						top_d     = mem_rdata;
						res_d     = top_q;
						state_d   = rpn_pkg::ST_SWP;
					end
					default: begin
						done_d  = 1'b1;
						state_d = rpn_pkg::ST_IDLE;
					end
				endcase
			end
			rpn_pkg::ST_DIV: begin
				if (!div_diff[DW]) begin
					rem_d = div_diff[DW-1:0];
				end else begin
					rem_d = div_sh[DW-1:0];
				end
				quo_d  = {quo_q[DW-2:0], !div_diff[DW]};
				dcnt_d = dcnt_q + rpn_pkg::DIV_CNT_W'(1);
				if (dcnt_q == rpn_pkg::DIV_CNT_W'(rpn_pkg::DIV_STEPS - 1)) begin
					state_d = rpn_pkg::ST_WR;
				end
			end
			rpn_pkg::ST_WR: begin
				mem_we    = 1'b1;
				mem_waddr = cnt_m2[AW-1:0];
				mem_wdata = (kind_q == rpn_pkg::KIND_DIV) ? quo_fix : res_q;
				top_d     = mem_wdata;
				count_d   = cnt_m1;
				done_d    = 1'b1;
				state_d   = rpn_pkg::ST_IDLE;
			end
			rpn_pkg::ST_SWP: begin
				// second half of the swap: old top goes one place down
				mem_we    = 1'b1;
				mem_waddr = cnt_m2[AW-1:0];
				mem_wdata = res_q;
				done_d    = 1'b1;
				state_d   = rpn_pkg::ST_IDLE;
			end
			default: begin
				state_d = rpn_pkg::ST_IDLE;
			end
		endcase
	end

	assign busy      = (state_q != rpn_pkg::ST_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign top_value = top_q;
	assign depth     = rpn_pkg::DEPTH_W'(count_q);

	// The stack pointer never runs past the RAM
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	// An empty stack always shows a zero top
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (top_q == '0))
		else $error("empty stack with non-zero top");

	// An idle sequencer writes the RAM only for a command being transferred
	a_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpn_pkg::ST_IDLE && !start) |-> !mem_we)
		else $error("RAM write while idle");

	// No result strobe while the divider is iterating
	a_div_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rpn_pkg::ST_DIV) |-> !done_q)
		else $error("result strobe during division");

	// A RAM read is only issued for a command being transferred
	a_read_accept: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> accept)
		else $error("RAM read without a command transfer");

endmodule

FILE: hw/rtl/rpn_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rpn_ram #(
	parameter int WIDTH = rpn_pkg::DATA_W,
	parameter int DEPTH = rpn_pkg::STACK_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
